// ===== hdl/assert_macros.svh =====
// Assertion macros of the keypad scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MKS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define MKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mks_pkg.sv =====
// Types, constants and the key map of the matrix keypad scanner.
package mks_pkg;

  localparam int COL_W      = 4;
  localparam int ROW_W      = 4;
  localparam int CODE_W     = 7;
  localparam int WAIT_W     = 16;
  localparam int PERIOD_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [WAIT_W-1:0]   DEBOUNCE_RST  = 16'd2000;
  localparam logic [PERIOD_W-1:0] HALF_RST      = 8'd50;
  localparam logic [PERIOD_W-1:0] PERIODS_RST   = 8'd250;
  localparam logic [WAIT_W-1:0]   GAP_RST       = 16'd500;

  // ASCII codes of the keys.
  localparam logic [CODE_W-1:0] KEY_0     = 7'h30;
  localparam logic [CODE_W-1:0] KEY_1     = 7'h31;
  localparam logic [CODE_W-1:0] KEY_2     = 7'h32;
  localparam logic [CODE_W-1:0] KEY_3     = 7'h33;
  localparam logic [CODE_W-1:0] KEY_4     = 7'h34;
  localparam logic [CODE_W-1:0] KEY_5     = 7'h35;
  localparam logic [CODE_W-1:0] KEY_6     = 7'h36;
  localparam logic [CODE_W-1:0] KEY_7     = 7'h37;
  localparam logic [CODE_W-1:0] KEY_8     = 7'h38;
  localparam logic [CODE_W-1:0] KEY_9     = 7'h39;
  localparam logic [CODE_W-1:0] KEY_DIV   = 7'h2F;
  localparam logic [CODE_W-1:0] KEY_MUL   = 7'h2A;
  localparam logic [CODE_W-1:0] KEY_SUB   = 7'h2D;
  localparam logic [CODE_W-1:0] KEY_ADD   = 7'h2B;
  localparam logic [CODE_W-1:0] KEY_CLR   = 7'h43;
  localparam logic [CODE_W-1:0] KEY_EQ    = 7'h3D;
  localparam logic [CODE_W-1:0] KEY_NONE  = 7'h00;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESTRICTED = 3'd0,
    CFG_DEBOUNCE   = 3'd1,
    CFG_HALF       = 3'd2,
    CFG_PERIODS    = 3'd3,
    CFG_GAP        = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_TONE     = 2'd2,
    PH_GAP      = 2'd3
  } phase_t;

  typedef struct packed {
    logic                restricted_mode;
    logic [WAIT_W-1:0]   debounce_ticks;
    logic [PERIOD_W-1:0] tone_half_ticks;
    logic [PERIOD_W-1:0] tone_periods;
    logic [WAIT_W-1:0]   gap_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [1:0]          row_index;
    logic [1:0]          column_index;
    logic [WAIT_W-1:0]   wait_count;
    logic [PERIOD_W-1:0] period_count;
    logic                tone_level;
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_drive;
    logic              buzzer;
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
  } result_t;

  // Key at a row and column of the 4x4 matrix.
  function automatic logic [CODE_W-1:0] key_at(logic [1:0] row, logic [1:0] col);
    logic [CODE_W-1:0] k;
    case ({row, col})
      4'd0:    k = KEY_7;
      4'd1:    k = KEY_8;
      4'd2:    k = KEY_9;
      4'd3:    k = KEY_DIV;
      4'd4:    k = KEY_4;
      4'd5:    k = KEY_5;
      4'd6:    k = KEY_6;
      4'd7:    k = KEY_MUL;
      4'd8:    k = KEY_1;
      4'd9:    k = KEY_2;
      4'd10:   k = KEY_3;
      4'd11:   k = KEY_SUB;
      4'd12:   k = KEY_CLR;
      4'd13:   k = KEY_0;
      4'd14:   k = KEY_EQ;
      4'd15:   k = KEY_ADD;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/mks_if.sv =====
// Channel interfaces of the keypad scanner: column input, result output, configuration.
interface mks_in_if import mks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink (input valid, input column_levels, output ready);
endinterface

interface mks_out_if import mks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row_drive;
  logic              buzzer;
  logic              key_valid;
  logic [CODE_W-1:0] key_code;

  modport source (output valid, output row_drive, output buzzer, output key_valid,
                  output key_code, input ready);
  modport sink (input valid, input row_drive, input buzzer, input key_valid,
                input key_code, output ready);
endinterface

interface mks_cfg_if import mks_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mks_cfg.sv =====
// Configuration register file of the keypad scanner.
module mks_cfg
  import mks_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mks_cfg_if.sink    cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken; an unused index leaves everything alone.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_RESTRICTED: cfg_nxt.restricted_mode = cfg_ch.data[0];
        CFG_DEBOUNCE:   cfg_nxt.debounce_ticks  = cfg_ch.data[WAIT_W-1:0];
        CFG_HALF:       cfg_nxt.tone_half_ticks = cfg_ch.data[PERIOD_W-1:0];
        CFG_PERIODS:    cfg_nxt.tone_periods    = cfg_ch.data[PERIOD_W-1:0];
        CFG_GAP:        cfg_nxt.gap_ticks       = cfg_ch.data[WAIT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.restricted_mode <= 1'b0;
      cfg_r.debounce_ticks  <= DEBOUNCE_RST;
      cfg_r.tone_half_ticks <= HALF_RST;
      cfg_r.tone_periods    <= PERIODS_RST;
      cfg_r.gap_ticks       <= GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/mks_step.sv =====
// Next-state and result logic for one tick of the keypad scanner.
module mks_step
  import mks_pkg::*;
(
  input  state_t           cur,
  input  cfg_t             cfg,
  input  logic [COL_W-1:0] cols,
  output state_t           nxt,
  output result_t          res
);

  state_t              eff;
  logic                col_low;
  logic [WAIT_W-1:0]   wait_inc;
  logic [PERIOD_W-1:0] period_inc;
  logic [CODE_W-1:0]   key;
  logic                key_ok;
  logic [1:0]          adv_row;
  logic [1:0]          adv_col;

  always_comb begin
    // Restricted mode pins the scan to row 4 at column 1 or 3.
    eff = cur;
    if (cur.phase == PH_SCAN && cfg.restricted_mode) begin
      eff.row_index    = 2'd3;
      eff.column_index = cur.column_index & 2'b10;
    end

    col_low    = !cols[eff.column_index];
    wait_inc   = eff.wait_count + 1'b1;
    period_inc = eff.period_count + 1'b1;
    key        = key_at(eff.row_index, eff.column_index);
    key_ok     = !cfg.restricted_mode || key == KEY_CLR || key == KEY_EQ;

    // Position of the next column to check.
    if (cfg.restricted_mode) begin
      adv_row = 2'd3;
      adv_col = {!eff.column_index[1], 1'b0};
    end else if (eff.column_index == 2'd3) begin
      adv_row = eff.row_index + 2'd1;
      adv_col = 2'd0;
    end else begin
      adv_row = eff.row_index;
      adv_col = eff.column_index + 2'd1;
    end

    nxt           = eff;
    res.row_drive = ~(ROW_W'(1) << eff.row_index);
    res.buzzer    = 1'b0;
    res.key_valid = 1'b0;
    res.key_code  = KEY_NONE;

    case (eff.phase)
      PH_SCAN: begin
        if (col_low) begin
          nxt.phase      = PH_DEBOUNCE;
          nxt.wait_count = '0;
        end else begin
          nxt.row_index    = adv_row;
          nxt.column_index = adv_col;
        end
      end
      PH_DEBOUNCE: begin
        nxt.wait_count = wait_inc;
        if (wait_inc >= cfg.debounce_ticks) begin
          nxt.wait_count = '0;
          if (col_low && key_ok) begin
            res.key_valid    = 1'b1;
            res.key_code     = key;
            nxt.phase        = PH_TONE;
            nxt.period_count = '0;
            nxt.tone_level   = 1'b1;
          end else begin
            nxt.phase        = PH_SCAN;
            nxt.row_index    = adv_row;
            nxt.column_index = adv_col;
          end
        end
      end
      PH_TONE: begin
        res.buzzer     = eff.tone_level;
        nxt.wait_count = wait_inc;
        if (wait_inc >= WAIT_W'(cfg.tone_half_ticks)) begin
          nxt.wait_count = '0;
          if (eff.tone_level) begin
            nxt.tone_level = 1'b0;
          end else begin
            nxt.tone_level   = 1'b1;
            nxt.period_count = period_inc;
            if (period_inc >= cfg.tone_periods) begin
              nxt.tone_level   = 1'b0;
              nxt.period_count = '0;
              nxt.row_index    = 2'd0;
              nxt.column_index = 2'd0;
              nxt.phase        = (cfg.gap_ticks == '0) ? PH_SCAN : PH_GAP;
            end
          end
        end
      end
      default: begin
        nxt.wait_count = wait_inc;
        if (wait_inc >= cfg.gap_ticks) begin
          nxt.wait_count   = '0;
          nxt.row_index    = 2'd0;
          nxt.column_index = 2'd0;
          nxt.phase        = PH_SCAN;
        end
      end
    endcase
  end

endmodule

// ===== hdl/matrix_keypad_scanner_top.sv =====
// Top level of the 4x4 matrix keypad scanner with debounce and beep.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------
//   in_ch    | sink      | column_levels, one word per scan tick
//   out_ch   | source    | row_drive, buzzer, key_valid, key_code
//   cfg_ch   | sink      | index, data register write
//
// Each input word yields exactly one result word, passing through the input
// register and then the result register. A new word is taken every cycle unless
// the output stalls; the scan state register sets this, being updated in the
// same cycle the word moves from input to result register.
// Reset clears the scan state, the valid flags and the registers to defaults.
// When the result is not taken, the input register holds and in_ch.ready drops
// only once both registers are full.
module matrix_keypad_scanner_top
  import mks_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mks_in_if.sink     in_ch,
  mks_out_if.source  out_ch,
  mks_cfg_if.sink    cfg_ch
);

  `include "assert_macros.svh"

  cfg_t             cfg;
  state_t           st_r;
  state_t           st_nxt;
  result_t          step_res;
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_cols_r;
  logic             out_valid_r;
  result_t          out_r;
  logic             s1_fire;

  mks_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  mks_step u_step (
    .cur  (st_r),
    .cfg  (cfg),
    .cols (s1_cols_r),
    .nxt  (st_nxt),
    .res  (step_res)
  );

  // The input word advances when the result register is free or being emptied.
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cols_r <= in_ch.column_levels;
    end
  end

  // Scan state moves on once per word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= PH_SCAN;
      st_r.row_index    <= 2'd0;
      st_r.column_index <= 2'd0;
      st_r.wait_count   <= '0;
      st_r.period_count <= '0;
      st_r.tone_level   <= 1'b0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= step_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_drive = out_r.row_drive;
  assign out_ch.buzzer    = out_r.buzzer;
  assign out_ch.key_valid = out_r.key_valid;
  assign out_ch.key_code  = out_r.key_code;

  // A reported key always leads into the tone burst.
  `MKS_ASSERT_NEXT(a_report_starts_tone, s1_fire && step_res.key_valid, st_r.phase == PH_TONE, "key report did not start the tone")

  // A held result word keeps the step from advancing the scan state.
  `MKS_ASSERT_NEXT(a_stall_holds_state, out_valid_r && !out_ch.ready && s1_valid_r, st_r == $past(st_r), "scan state moved during an output stall")

  // Exactly one row is driven and a code is shown only with a report.
  `MKS_ASSERT(a_result_shape, !out_valid_r || ($onehot(~out_r.row_drive) && ((out_r.key_code != KEY_NONE) == out_r.key_valid)), "malformed result word")

endmodule
